// File: rtl/fde_pkg.sv
// ----------------------------------------------------------------------------
// fde_pkg
// Shared widths, register codes, reset values and configuration structs for
// the feedback delay echo.
// ----------------------------------------------------------------------------
package fde_pkg;

  localparam int RING_W      = 17;
  localparam int DELAY_W     = 16;
  localparam int FB_W        = 15;
  localparam int MIX_W       = 16;
  localparam int CC_W        = 2;
  localparam int CHAN_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = RING_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int FRAC_BITS   = 15;
  localparam int Q15_ONE     = 32768;
  localparam int Q15_HALF    = 16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RING_FRAMES   = 3'd0,
    REG_DELAY_FRAMES  = 3'd1,
    REG_FEEDBACK_GAIN = 3'd2,
    REG_WET_MIX       = 3'd3,
    REG_CHANNEL_COUNT = 3'd4
  } cfg_reg_t;

  localparam logic [RING_W-1:0]  RING_RST  = 17'd65536;
  localparam logic [DELAY_W-1:0] DELAY_RST = 16'd12000;
  localparam logic [FB_W-1:0]    FB_RST    = 15'd16384;
  localparam logic [MIX_W-1:0]   MIX_RST   = 16'd16384;
  localparam logic [CC_W-1:0]    CC_RST    = 2'd2;

  // settings used by the address side
  typedef struct packed {
    logic [RING_W-1:0]  ring_frames;
    logic [DELAY_W-1:0] delay_frames;
    logic [CC_W-1:0]    channel_count;
  } fcfg_t;

  // settings used by the arithmetic side
  typedef struct packed {
    logic [FB_W-1:0]  feedback_gain;
    logic [MIX_W-1:0] wet_mix;
  } bcfg_t;

endpackage

// File: rtl/fde_queue.sv
// ----------------------------------------------------------------------------
// fde_queue
// Short register FIFO between the address front end and the ring back end.
// ----------------------------------------------------------------------------
module fde_queue #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         full,
  output logic         valid,
  output logic [W-1:0] rdata
);
  import fde_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  assign full  = (count_r == NW'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign rdata = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

endmodule

// File: rtl/fde_front.sv
// ----------------------------------------------------------------------------
// fde_front
// Takes input items, clamps the settings, decides whether the channel is
// held in the ring, works out read and write entries and keeps the write slot.
// ----------------------------------------------------------------------------
module fde_front #(
  parameter int MAX_FRAMES   = 65536,
  parameter int MAX_CHANNELS = 2,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fde_pkg::fcfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample_in,
  input  logic [fde_pkg::CHAN_W-1:0]       in_channel,
  input  logic                             in_frame_last,
  input  logic                             q_full,
  input  logic                             clearing,
  output logic                             q_push,
  output logic [SAMPLE_BITS+fde_pkg::CHAN_W+2+
                2*$clog2(MAX_FRAMES*MAX_CHANNELS)-1:0] q_wdata
);
  import fde_pkg::*;

  localparam int SW  = $clog2(MAX_FRAMES);
  localparam int FW  = SW + 1;
  localparam int CW  = (FW > RING_W) ? FW : RING_W;
  localparam int AW  = $clog2(MAX_FRAMES * MAX_CHANNELS);
  localparam int CCW = CHAN_W + 1;

  logic [SW-1:0]  slot_r, slot_nxt;
  logic [CW-1:0]  rf_ext, rf_c, d_ext, d_c, slot_ext, rd_ext;
  logic [FW-1:0]  slot_inc;
  logic [CCW-1:0] cc_ext, cc_c;
  logic           stored;
  logic [AW-1:0]  waddr, raddr;

  always_comb begin
    rf_ext = CW'(cfg.ring_frames);
    if (rf_ext < CW'(2)) begin
      rf_c = CW'(2);
    end else if (rf_ext > CW'(MAX_FRAMES)) begin
      rf_c = CW'(MAX_FRAMES);
    end else begin
      rf_c = rf_ext;
    end

    // delay held within one .. ring length minus one
    d_ext = CW'(cfg.delay_frames);
    if (d_ext == '0) begin
      d_c = CW'(1);
    end else if (d_ext >= rf_c) begin
      d_c = rf_c - CW'(1);
    end else begin
      d_c = d_ext;
    end

    slot_ext = CW'(slot_r);
    rd_ext   = (slot_ext >= d_c) ? (slot_ext - d_c) : (slot_ext + rf_c - d_c);

    cc_ext = CCW'(cfg.channel_count);
    if (cc_ext == '0) begin
      cc_c = CCW'(1);
    end else if (cc_ext > CCW'(MAX_CHANNELS)) begin
      cc_c = CCW'(MAX_CHANNELS);
    end else begin
      cc_c = cc_ext;
    end
    stored = (CCW'(in_channel) < cc_c);

    waddr = AW'(slot_r) * AW'(MAX_CHANNELS) + AW'(in_channel);
    raddr = AW'(rd_ext[SW-1:0]) * AW'(MAX_CHANNELS) + AW'(in_channel);

    // a slot left beyond a shrunk ring also returns to zero here
    slot_inc = FW'(slot_r) + FW'(1);
    slot_nxt = (slot_inc >= rf_c[FW-1:0]) ? '0 : slot_inc[SW-1:0];
  end

  assign in_ready = !q_full && !clearing;
  assign q_push   = in_valid && in_ready;
  assign q_wdata  = {in_sample_in, in_channel, in_frame_last, stored, waddr, raddr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (q_push && in_frame_last) begin
      slot_r <= slot_nxt;
    end
  end

endmodule

// File: rtl/fde_back.sv
// ----------------------------------------------------------------------------
// fde_back
// Ring memory, feedback write-back and dry/wet blend. Clears the ring after
// reset, one entry a cycle.
// ----------------------------------------------------------------------------
module fde_back #(
  parameter int MAX_FRAMES   = 65536,
  parameter int MAX_CHANNELS = 2,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fde_pkg::bcfg_t                   cfg,
  input  logic                             q_valid,
  input  logic [SAMPLE_BITS+fde_pkg::CHAN_W+2+
                2*$clog2(MAX_FRAMES*MAX_CHANNELS)-1:0] q_rdata,
  output logic                             q_pop,
  output logic                             clearing,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_BITS-1:0]    out_sample_out,
  output logic [fde_pkg::CHAN_W-1:0]       out_channel_out,
  output logic                             out_frame_last_out
);
  import fde_pkg::*;

  localparam int SB         = SAMPLE_BITS;
  localparam int RING_DEPTH = MAX_FRAMES * MAX_CHANNELS;
  localparam int AW         = $clog2(RING_DEPTH);

  function automatic logic signed [SB-1:0] sat_w(input logic signed [SB+2:0] x);
    logic signed [SB+2:0] hi, lo;
    hi = {4'b0000, {(SB-1){1'b1}}};
    lo = {4'b1111, {(SB-1){1'b0}}};
    if (x > hi) begin
      return hi[SB-1:0];
    end else if (x < lo) begin
      return lo[SB-1:0];
    end
    return x[SB-1:0];
  endfunction

  // queue head
  logic signed [SB-1:0] h_dry;
  logic [CHAN_W-1:0]    h_chan;
  logic                 h_last, h_stored;
  logic [AW-1:0]        h_waddr, h_raddr;

  assign {h_dry, h_chan, h_last, h_stored, h_waddr, h_raddr} = q_rdata;

  logic signed [SB-1:0] ring [RING_DEPTH];
  logic                 clr_busy_r;
  logic [AW-1:0]        clr_addr_r;

  logic adv, wr_en;

  // stage 1: read data, feedback write-back, blend products
  logic                 s1_valid_r, s1_last_r, s1_stored_r, fwd_r;
  logic signed [SB-1:0] s1_dry_r, rdata_r, wdata_r;
  logic [CHAN_W-1:0]    s1_chan_r;
  logic [AW-1:0]        s1_waddr_r;

  logic signed [SB-1:0]  delayed, stored_val;
  logic signed [SB+15:0] fb_prod, fb_sum;
  logic signed [SB:0]    fb_rnd;
  logic signed [SB+1:0]  st_sum;
  logic [MIX_W-1:0]      mix_c, inv_c;
  logic signed [SB+16:0] p_dry, p_wet;

  // stage 2: sum, round, saturate
  logic                  s2_valid_r, s2_last_r, s2_stored_r;
  logic signed [SB+16:0] s2_pdry_r, s2_pwet_r;
  logic signed [SB-1:0]  s2_dry_r, result;
  logic [CHAN_W-1:0]     s2_chan_r;
  logic signed [SB+17:0] acc;
  logic signed [SB+2:0]  acc_rnd;

  logic                  out_valid_r, out_last_r;
  logic signed [SB-1:0]  out_sample_r;
  logic [CHAN_W-1:0]     out_chan_r;

  assign adv      = !out_valid_r || out_ready;
  assign q_pop    = adv && q_valid && !clr_busy_r;
  assign wr_en    = adv && s1_valid_r && s1_stored_r;
  assign clearing = clr_busy_r;

  always_comb begin
    // the previous item's write-back to the same entry has not reached the read data yet
    delayed = fwd_r ? wdata_r : rdata_r;

    fb_prod    = delayed * $signed({1'b0, cfg.feedback_gain});
    fb_sum     = fb_prod + (SB+16)'(Q15_HALF);
    fb_rnd     = fb_sum[SB+15:FRAC_BITS];
    st_sum     = (SB+2)'(s1_dry_r) + (SB+2)'(fb_rnd);
    stored_val = sat_w((SB+3)'(st_sum));

    mix_c = (cfg.wet_mix > MIX_W'(Q15_ONE)) ? MIX_W'(Q15_ONE) : cfg.wet_mix;
    inv_c = MIX_W'(Q15_ONE) - mix_c;
    p_dry = s1_dry_r * $signed({1'b0, inv_c});
    p_wet = delayed * $signed({1'b0, mix_c});

    acc     = (SB+18)'(s2_pdry_r) + (SB+18)'(s2_pwet_r) + (SB+18)'(Q15_HALF);
    acc_rnd = acc[SB+17:FRAC_BITS];
    result  = s2_stored_r ? sat_w(acc_rnd) : s2_dry_r;
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      ring[clr_addr_r] <= '0;
    end else if (wr_en) begin
      ring[s1_waddr_r] <= stored_val;
    end
    if (q_pop) begin
      rdata_r <= ring[h_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(RING_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_pop;
      fwd_r       <= q_pop && h_stored && s1_valid_r && s1_stored_r &&
                     (h_raddr == s1_waddr_r);
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_dry_r    <= h_dry;
      s1_chan_r   <= h_chan;
      s1_last_r   <= h_last;
      s1_stored_r <= h_stored;
      s1_waddr_r  <= h_waddr;
    end
    if (wr_en) begin
      wdata_r <= stored_val;
    end
    if (adv) begin
      s2_pdry_r    <= p_dry;
      s2_pwet_r    <= p_wet;
      s2_dry_r     <= s1_dry_r;
      s2_chan_r    <= s1_chan_r;
      s2_last_r    <= s1_last_r;
      s2_stored_r  <= s1_stored_r;
      out_sample_r <= result;
      out_chan_r   <= s2_chan_r;
      out_last_r   <= s2_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample_out     = out_sample_r;
  assign out_channel_out    = out_chan_r;
  assign out_frame_last_out = out_last_r;

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s1_valid_r && !s2_valid_r && !out_valid_r)
    else $error("item in flight while ring is being cleared");

  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r && s1_stored_r)
    else $error("forward flag without a stored item in stage 1");

  a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> $past(clr_addr_r) == AW'(RING_DEPTH - 1))
    else $error("clear pass ended early");

endmodule

// File: rtl/feedback_delay_echo.sv
// ----------------------------------------------------------------------------
// feedback_delay_echo
// Multichannel feedback echo over an interleaved sample stream, with the
// delay ring held in one memory.
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid/in_ready    in_sample_in, in_channel,
//                                                in_frame_last
//   out_*        output     out_valid/out_ready  out_sample_out, out_channel_out,
//                                                out_frame_last_out
//   cfg_*        input      cfg_we               cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ready stays high; each item passes
// through the queue, read/feedback stage, blend stage and output register.
// The feedback write-back and the ring read of the next item share one cycle.
// After reset all MAX_FRAMES*MAX_CHANNELS ring entries are cleared, one at a time
// (131072 with the defaults); in_ready stays low meanwhile.
// A stall on the output fills the four-entry queue before in_ready drops.
// ----------------------------------------------------------------------------
module feedback_delay_echo #(
  parameter int MAX_FRAMES   = 65536,
  parameter int MAX_CHANNELS = 2,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  input  logic [fde_pkg::CHAN_W-1:0]          in_channel,
  input  logic                                in_frame_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_sample_out,
  output logic [fde_pkg::CHAN_W-1:0]          out_channel_out,
  output logic                                out_frame_last_out,
  input  logic                                cfg_we,
  input  logic [fde_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fde_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import fde_pkg::*;

  localparam int AW = $clog2(MAX_FRAMES * MAX_CHANNELS);
  localparam int QW = SAMPLE_BITS + CHAN_W + 2 + 2 * AW;

  fcfg_t fcfg_r;
  bcfg_t bcfg_r;

  logic          q_push, q_pop, q_full, q_valid, clearing;
  logic [QW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcfg_r <= '{ring_frames: RING_RST, delay_frames: DELAY_RST, channel_count: CC_RST};
      bcfg_r <= '{feedback_gain: FB_RST, wet_mix: MIX_RST};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RING_FRAMES:   fcfg_r.ring_frames   <= cfg_wdata[RING_W-1:0];
        REG_DELAY_FRAMES:  fcfg_r.delay_frames  <= cfg_wdata[DELAY_W-1:0];
        REG_FEEDBACK_GAIN: bcfg_r.feedback_gain <= cfg_wdata[FB_W-1:0];
        REG_WET_MIX:       bcfg_r.wet_mix       <= cfg_wdata[MIX_W-1:0];
        REG_CHANNEL_COUNT: fcfg_r.channel_count <= cfg_wdata[CC_W-1:0];
        default: ;
      endcase
    end
  end

  fde_front #(
    .MAX_FRAMES   (MAX_FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (fcfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .in_channel    (in_channel),
    .in_frame_last (in_frame_last),
    .q_full        (q_full),
    .clearing      (clearing),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  fde_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  fde_back #(
    .MAX_FRAMES   (MAX_FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (bcfg_r),
    .q_valid            (q_valid),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_out     (out_sample_out),
    .out_channel_out    (out_channel_out),
    .out_frame_last_out (out_frame_last_out)
  );

endmodule
